FILE: rtl/dtbp_pkg.sv
// Package for the dual token bucket packet policer.
// Holds shared constants, FSM encoding and divider request/response types.
// No dependencies.
`default_nettype none
package dtbp_pkg;

  localparam logic [31:0] TICKS_PER_SECOND = 32'd1000;
  localparam logic [7:0]  PROTO_TCP        = 8'd6;
  localparam logic [7:0]  PROTO_UDP        = 8'd17;
  localparam logic [3:0]  IP_V4            = 4'd4;
  localparam logic [1:0]  IFACE_UPLINK     = 2'd0;
  localparam logic [1:0]  IFACE_ACCESS     = 2'd1;

  localparam logic [31:0] BYTE_RATE_RST    = 32'd250000;
  localparam logic [30:0] BYTE_BURST_RST   = 31'd65536;
  localparam logic [31:0] PKT_RATE_RST     = 32'd100;
  localparam logic [30:0] PKT_BURST_RST    = 31'd50;

  localparam int unsigned PADDR_W = 5;

  localparam logic [2:0] REG_BYTE_RATE  = 3'd0;
  localparam logic [2:0] REG_BYTE_BURST = 3'd1;
  localparam logic [2:0] REG_PKT_RATE   = 3'd2;
  localparam logic [2:0] REG_PKT_BURST  = 3'd3;
  localparam logic [2:0] REG_UPLINK_EN  = 3'd4;
  localparam logic [2:0] REG_ACCESS_EN  = 3'd5;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_REF    = 9'b000000010,
    S_MUL    = 9'b000000100,
    S_DIV1   = 9'b000001000,
    S_MUL2   = 9'b000010000,
    S_DIV2   = 9'b000100000,
    S_DECIDE = 9'b001000000,
    S_OUT    = 9'b010000000,
    S_NEXT   = 9'b100000000
  } state_e;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
    logic [31:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

FILE: rtl/dtbp_in_if.sv
// Input channel of the policer: valid/ready handshake with packet fields.
// No dependencies.
`default_nettype none
interface dtbp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  interface_req;
  logic        header_short;
  logic [3:0]  ip_version;
  logic [7:0]  protocol;
  logic [15:0] total_len;
  logic [31:0] now_ms;

  modport source (output valid, interface_req, header_short, ip_version, protocol,
                  total_len, now_ms, input ready);
  modport sink (input valid, interface_req, header_short, ip_version, protocol,
                total_len, now_ms, output ready);
endinterface
`default_nettype wire

FILE: rtl/dtbp_out_if.sv
// Result channel of the policer: valid/ready handshake with verdict fields.
// No dependencies.
`default_nettype none
interface dtbp_out_if;
  logic        valid;
  logic        ready;
  logic        dropped;
  logic        policed;
  logic        udp_seen;
  logic        byte_short;
  logic        packet_short;
  logic [30:0] byte_tokens_min;
  logic [30:0] packet_tokens_min;

  modport source (output valid, dropped, policed, udp_seen, byte_short, packet_short,
                  byte_tokens_min, packet_tokens_min, input ready);
  modport sink (input valid, dropped, policed, udp_seen, byte_short, packet_short,
                byte_tokens_min, packet_tokens_min, output ready);
endinterface
`default_nettype wire

FILE: rtl/dtbp_div.sv
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
// Depends on dtbp_pkg for the request and response types.
`default_nettype none
module dtbp_div
  import dtbp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] dvd_q, dvd_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] dsr_q, dsr_d;
  logic [32:0] part;
  logic [32:0] diff;

  assign part = {rem_q, dvd_q[63]};
  assign diff = part - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      if (!diff[32]) begin
        rem_d = diff[31:0];
        dvd_d = {dvd_q[62:0], 1'b1};
      end else begin
        rem_d = part[31:0];
        dvd_d = {dvd_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q;
  assign rsp_o.rem  = rem_q;

endmodule
`default_nettype wire

FILE: rtl/dual_token_bucket_packet_policer_unit.sv
// Unpoliced packet: S_IDLE goes to S_OUT, which registers the result; next packet is taken in S_IDLE.
// Policed packet: S_REF, S_MUL, S_DIV1, S_MUL2, S_DIV2, S_NEXT refill the byte then the packet bucket,
// with the shared divider run at most twice per refill, then S_DECIDE and S_OUT; a waiting result stalls.
// Reset is asynchronous and active low; it restores the register defaults and fills
// every bucket to its reset level with no refill time recorded.
// Depends on dtbp_pkg, dtbp_in_if, dtbp_out_if and dtbp_div.
`default_nettype none
module dual_token_bucket_packet_policer_unit
  import dtbp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  dtbp_in_if.sink                 in_i,
  dtbp_out_if.source              out_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  state_e state_q, state_d;

  logic [31:0] byte_rate_q, pkt_rate_q;
  logic [30:0] byte_burst_q, pkt_burst_q;
  logic        uplink_en_q, access_en_q;

  logic [30:0] byte_tok_q [2];
  logic [30:0] pkt_tok_q [2];
  logic [31:0] byte_last_q [2];
  logic [31:0] pkt_last_q [2];

  logic        dir_q, sel_q;
  logic [15:0] len_q;
  logic [31:0] now_q;
  logic        udp_q, pol_q, drop_q, bshort_q, pshort_q;
  logic [63:0] prod_q;

  logic        out_valid_q;
  logic        o_drop_q, o_pol_q, o_udp_q, o_bshort_q, o_pshort_q;
  logic [30:0] o_bmin_q, o_pmin_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic        cfg_wr;
  logic [2:0]  cfg_idx;
  logic        in_acc;
  logic        is_up, is_acc, is_reg, is_udp, is_go;
  logic [30:0] tok_cur, burst_cur;
  logic [31:0] last_cur, rate_cur, dt;
  logic [63:0] sum;
  logic [30:0] tok_new;
  logic        len_fits, pkts_ok;
  logic        out_free;

  dtbp_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (cfg_idx)
      REG_BYTE_RATE:  prdata = byte_rate_q;
      REG_BYTE_BURST: prdata = {1'b0, byte_burst_q};
      REG_PKT_RATE:   prdata = pkt_rate_q;
      REG_PKT_BURST:  prdata = {1'b0, pkt_burst_q};
      REG_UPLINK_EN:  prdata = {31'd0, uplink_en_q};
      REG_ACCESS_EN:  prdata = {31'd0, access_en_q};
      default:        prdata = '0;
    endcase
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  assign is_up  = (in_i.interface_req == IFACE_UPLINK) && uplink_en_q;
  assign is_acc = (in_i.interface_req == IFACE_ACCESS) && access_en_q;
  assign is_reg = !in_i.header_short && (is_up || is_acc) && (in_i.ip_version == IP_V4);
  assign is_udp = is_reg && (in_i.protocol == PROTO_UDP);
  assign is_go  = is_reg && ((in_i.protocol == PROTO_TCP) || (is_udp && is_up));

  assign tok_cur   = sel_q ? pkt_tok_q[dir_q] : byte_tok_q[dir_q];
  assign last_cur  = sel_q ? pkt_last_q[dir_q] : byte_last_q[dir_q];
  assign rate_cur  = sel_q ? pkt_rate_q : byte_rate_q;
  assign burst_cur = sel_q ? pkt_burst_q : byte_burst_q;
  assign dt        = now_q - last_cur;
  assign sum       = {33'd0, tok_cur} + div_rsp.quot;
  assign tok_new   = (sum > {33'd0, burst_cur}) ? burst_cur : sum[30:0];

  assign len_fits = byte_tok_q[dir_q] >= {15'd0, len_q};
  assign pkts_ok  = (pkt_rate_q == 32'd0) || (pkt_tok_q[dir_q] != 31'd0);
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    div_req.start    = (state_q == S_MUL) || (state_q == S_MUL2);
    div_req.dividend = prod_q;
    div_req.divisor  = (state_q == S_MUL) ? TICKS_PER_SECOND : rate_cur;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = is_go ? S_REF : S_OUT;
      end
      S_REF: begin
        if (last_cur == 32'd0 || dt == 32'd0 || rate_cur == 32'd0) state_d = S_NEXT;
        else state_d = S_MUL;
      end
      S_MUL:  state_d = S_DIV1;
      S_DIV1: begin
        if (div_rsp.done) state_d = (div_rsp.quot == 64'd0) ? S_NEXT : S_MUL2;
      end
      S_MUL2: state_d = S_DIV2;
      S_DIV2: begin
        if (div_rsp.done) state_d = S_NEXT;
      end
      S_NEXT:   state_d = sel_q ? S_DECIDE : S_REF;
      S_DECIDE: state_d = S_OUT;
      S_OUT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      byte_rate_q  <= BYTE_RATE_RST;
      byte_burst_q <= BYTE_BURST_RST;
      pkt_rate_q   <= PKT_RATE_RST;
      pkt_burst_q  <= PKT_BURST_RST;
      uplink_en_q  <= 1'b0;
      access_en_q  <= 1'b0;
      for (int d = 0; d < 2; d++) begin
        byte_tok_q[d]  <= BYTE_BURST_RST;
        pkt_tok_q[d]   <= PKT_BURST_RST;
        byte_last_q[d] <= '0;
        pkt_last_q[d]  <= '0;
      end
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_BYTE_RATE: byte_rate_q <= pwdata;
          REG_BYTE_BURST: begin
            byte_burst_q <= pwdata[30:0];
            for (int d = 0; d < 2; d++)
              if (byte_tok_q[d] > pwdata[30:0]) byte_tok_q[d] <= pwdata[30:0];
          end
          REG_PKT_RATE: pkt_rate_q <= pwdata;
          REG_PKT_BURST: begin
            pkt_burst_q <= pwdata[30:0];
            for (int d = 0; d < 2; d++)
              if (pkt_tok_q[d] > pwdata[30:0]) pkt_tok_q[d] <= pwdata[30:0];
          end
          REG_UPLINK_EN: uplink_en_q <= pwdata[0];
          REG_ACCESS_EN: access_en_q <= pwdata[0];
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: sel_q <= 1'b0;
        S_REF: begin
          if (last_cur == 32'd0) begin
            if (sel_q) pkt_last_q[dir_q] <= now_q;
            else byte_last_q[dir_q] <= now_q;
          end
        end
        S_DIV1: begin
          if (div_rsp.done && div_rsp.quot != 64'd0) begin
            if (sel_q) pkt_tok_q[dir_q] <= tok_new;
            else byte_tok_q[dir_q] <= tok_new;
          end
        end
        S_DIV2: begin
          if (div_rsp.done) begin
            if (sel_q) pkt_last_q[dir_q] <= last_cur + div_rsp.quot[31:0];
            else byte_last_q[dir_q] <= last_cur + div_rsp.quot[31:0];
          end
        end
        S_NEXT: sel_q <= 1'b1;
        S_DECIDE: begin
          if (len_fits && pkts_ok) begin
            byte_tok_q[dir_q] <= byte_tok_q[dir_q] - {15'd0, len_q};
            if (pkt_rate_q != 32'd0) pkt_tok_q[dir_q] <= pkt_tok_q[dir_q] - 31'd1;
          end
        end
        default: ;
      endcase
      if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
      else if (out_o.valid && out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dir_q    <= is_acc;
      len_q    <= in_i.total_len;
      now_q    <= in_i.now_ms;
      udp_q    <= is_udp;
      pol_q    <= is_go;
      drop_q   <= 1'b0;
      bshort_q <= 1'b0;
      pshort_q <= 1'b0;
    end
    if (state_q == S_REF) prod_q <= 64'(dt) * 64'(rate_cur);
    if (state_q == S_DIV1 && div_rsp.done) prod_q <= prod_q - {32'd0, div_rsp.rem};
    if (state_q == S_DECIDE && !(len_fits && pkts_ok)) begin
      drop_q   <= 1'b1;
      bshort_q <= !len_fits;
      pshort_q <= !pkts_ok;
    end
    if (state_q == S_OUT && out_free) begin
      o_drop_q   <= drop_q;
      o_pol_q    <= pol_q;
      o_udp_q    <= udp_q;
      o_bshort_q <= bshort_q;
      o_pshort_q <= pshort_q;
      o_bmin_q   <= (byte_tok_q[0] < byte_tok_q[1]) ? byte_tok_q[0] : byte_tok_q[1];
      o_pmin_q   <= (pkt_tok_q[0] < pkt_tok_q[1]) ? pkt_tok_q[0] : pkt_tok_q[1];
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.dropped           = o_drop_q;
  assign out_o.policed           = o_pol_q;
  assign out_o.udp_seen          = o_udp_q;
  assign out_o.byte_short        = o_bshort_q;
  assign out_o.packet_short      = o_pshort_q;
  assign out_o.byte_tokens_min   = o_bmin_q;
  assign out_o.packet_tokens_min = o_pmin_q;

  a_byte_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_tok_q[0] <= byte_burst_q) && (byte_tok_q[1] <= byte_burst_q))
    else $error("byte bucket above its burst");

  a_pkt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pkt_tok_q[0] <= pkt_burst_q) && (pkt_tok_q[1] <= pkt_burst_q))
    else $error("packet bucket above its burst");

  a_used_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV2 && div_rsp.done) |-> (div_rsp.quot[63:32] == 32'd0))
    else $error("consumed time exceeds 32 bits");

endmodule
`default_nettype wire
